### rtl/core/tkema_pkg.sv
// ----------------------------------------------------------------------------
// tkema_pkg
// Shared widths and types of the Teager-Kaiser energy moving-average core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkema_pkg;

  localparam int CH_W       = 4;   // channel tag width
  localparam int SAMPLE_W   = 16;  // converter sample
  localparam int ENERGY_W   = 32;  // one energy value
  localparam int SUM_W      = 36;  // window sum, wraps
  localparam int AVG_W      = 36;  // Q.4 average
  localparam int FRAC_W     = 4;   // fraction bits of the average
  localparam int NUM_W      = SUM_W + FRAC_W;  // dividend magnitude
  localparam int DIG_W      = 8;   // quotient bits per divider stage
  localparam int DIV_STAGES = NUM_W / DIG_W;
  localparam int CMP_W      = 7;   // wide enough to compare a tag with 64

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  // Control of one word as it moves down the pipeline
  typedef struct packed {
    logic            vld;  // stage holds a word
    logic            inr;  // channel tag names a real channel
    logic [CH_W-1:0] ch;
  } item_ctl_t;

endpackage

`default_nettype wire

### rtl/core/tkema_energy.sv
// ----------------------------------------------------------------------------
// tkema_energy
// Per-channel sample history RAM with write forwarding; forms the two
// energy products and the ring slot address of each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkema_energy #(
  parameter int CHANNELS   = 12,
  parameter int WINDOW_LEN = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire logic                                  in_acc,
  input  wire logic [tkema_pkg::CH_W-1:0]            in_ch,
  input  wire logic signed [tkema_pkg::SAMPLE_W-1:0] in_x,
  output logic [$clog2(CHANNELS*WINDOW_LEN)-1:0]     rd_ring_addr,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_ch,
  output tkema_pkg::item_ctl_t                       s2_ctl_r,
  output logic signed [tkema_pkg::ENERGY_W-1:0]      s2_pa_r,
  output logic signed [tkema_pkg::ENERGY_W-1:0]      s2_pb_r,
  output logic [$clog2(CHANNELS*WINDOW_LEN)-1:0]     s2_addr_r,
  output logic                                       s2_wrap_r,
  output logic                                       s2_seen_r
);

  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int RA_W   = $clog2(CHANNELS * WINDOW_LEN);

  typedef struct packed {
    logic signed [tkema_pkg::SAMPLE_W-1:0] older;
    logic signed [tkema_pkg::SAMPLE_W-1:0] newer;
    logic [POS_W-1:0]                      pos;
    logic                                  wrap;  // ring filled once
  } chan_t;

  chan_t                mem_a [CHANNELS];
  logic [CHANNELS-1:0]  a_vld_r;

  tkema_pkg::item_ctl_t                  s1_ctl_r;
  logic signed [tkema_pkg::SAMPLE_W-1:0] s1_x_r;
  chan_t                                 a_rd_r;
  logic                                  s1_seen_r;

  logic                 lw_vld_r;
  logic [CIDX_W-1:0]    lw_ch_r;
  chan_t                lw_dat_r;

  logic [CIDX_W-1:0]    in_idx;
  logic                 in_inr;
  logic [CIDX_W-1:0]    s1_idx;
  logic                 hit;
  logic                 seen;
  logic                 last;
  logic                 wr;
  chan_t                cur;
  chan_t                a_nxt;
  logic signed [tkema_pkg::ENERGY_W-1:0] pa_nxt;
  logic signed [tkema_pkg::ENERGY_W-1:0] pb_nxt;

  assign in_idx = CIDX_W'(in_ch);
  assign in_inr = {{(tkema_pkg::CMP_W-tkema_pkg::CH_W){1'b0}}, in_ch}
                  < tkema_pkg::CMP_W'(CHANNELS);
  assign s1_idx = CIDX_W'(s1_ctl_r.ch);

  // previous word's write lands on the edge this word read: forward it
  assign hit  = lw_vld_r && (lw_ch_r == s1_idx);
  assign cur  = hit ? lw_dat_r : (s1_seen_r ? a_rd_r : '0);
  assign seen = hit || s1_seen_r;
  assign last = (cur.pos == POS_W'(WINDOW_LEN - 1));

  always_comb begin
    a_nxt.older = cur.newer;
    a_nxt.newer = s1_x_r;
    a_nxt.pos   = last ? '0 : cur.pos + 1'b1;
    a_nxt.wrap  = cur.wrap | last;
  end

  assign wr     = adv && s1_ctl_r.vld && s1_ctl_r.inr;
  assign pa_nxt = $signed(cur.newer) * $signed(cur.newer);
  assign pb_nxt = $signed(cur.older) * $signed(s1_x_r);

  assign rd_ring_addr = RA_W'(s1_idx) * RA_W'(WINDOW_LEN) + RA_W'(cur.pos);
  assign rd_ch        = s1_idx;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rd_r <= mem_a[in_idx];
    end
    if (wr) begin
      mem_a[s1_idx] <= a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= '0;
      lw_vld_r <= 1'b0;
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= '{vld: in_acc, inr: in_inr, ch: in_ch};
      s2_ctl_r <= s1_ctl_r;
      if (wr) begin
        a_vld_r[s1_idx] <= 1'b1;
        lw_vld_r        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r    <= in_x;
      s1_seen_r <= a_vld_r[in_idx];
      s2_pa_r   <= pa_nxt;
      s2_pb_r   <= pb_nxt;
      s2_addr_r <= rd_ring_addr;
      s2_wrap_r <= cur.wrap;
      s2_seen_r <= seen;
    end
    if (wr) begin
      lw_ch_r  <= s1_idx;
      lw_dat_r <= a_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tkema_window.sv
// ----------------------------------------------------------------------------
// tkema_window
// Energy ring RAM and window sum RAM; forms the new energy and updates the
// running sum with forwarding of the previous word's write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkema_window #(
  parameter int CHANNELS   = 12,
  parameter int WINDOW_LEN = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire logic [$clog2(CHANNELS*WINDOW_LEN)-1:0] rd_ring_addr,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_ch,
  input  wire tkema_pkg::item_ctl_t                  s2_ctl,
  input  wire logic signed [tkema_pkg::ENERGY_W-1:0] s2_pa,
  input  wire logic signed [tkema_pkg::ENERGY_W-1:0] s2_pb,
  input  wire logic [$clog2(CHANNELS*WINDOW_LEN)-1:0] s2_addr,
  input  wire logic                                  s2_wrap,
  input  wire logic                                  s2_seen,
  output tkema_pkg::item_ctl_t                       s3_ctl_r,
  output logic signed [tkema_pkg::ENERGY_W-1:0]      s3_energy_r,
  output logic signed [tkema_pkg::SUM_W-1:0]         s3_sum_r
);

  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_D = CHANNELS * WINDOW_LEN;

  logic signed [tkema_pkg::ENERGY_W-1:0] ring_mem [RING_D];
  logic signed [tkema_pkg::SUM_W-1:0]    sum_mem  [CHANNELS];

  logic signed [tkema_pkg::ENERGY_W-1:0] ring_rd_r;
  logic signed [tkema_pkg::SUM_W-1:0]    sum_rd_r;

  logic                                  lw_vld_r;
  logic [CIDX_W-1:0]                     lw_ch_r;
  logic signed [tkema_pkg::SUM_W-1:0]    lw_sum_r;

  logic [CIDX_W-1:0]                     s2_idx;
  logic                                  hit;
  logic                                  wr;
  logic signed [tkema_pkg::ENERGY_W:0]   diff;
  logic signed [tkema_pkg::ENERGY_W-1:0] e;
  logic signed [tkema_pkg::ENERGY_W-1:0] old_e;
  logic signed [tkema_pkg::SUM_W-1:0]    cur_sum;
  logic signed [tkema_pkg::SUM_W-1:0]    sum_nxt;

  assign s2_idx  = CIDX_W'(s2_ctl.ch);
  assign diff    = {s2_pa[tkema_pkg::ENERGY_W-1], s2_pa}
                 - {s2_pb[tkema_pkg::ENERGY_W-1], s2_pb};
  assign e       = diff[tkema_pkg::ENERGY_W-1:0];
  // slot not yet written on the first lap reads as zero
  assign old_e   = s2_wrap ? ring_rd_r : '0;
  assign hit     = lw_vld_r && (lw_ch_r == s2_idx);
  assign cur_sum = hit ? lw_sum_r : (s2_seen ? sum_rd_r : '0);
  assign sum_nxt = cur_sum - tkema_pkg::SUM_W'(old_e) + tkema_pkg::SUM_W'(e);
  assign wr      = adv && s2_ctl.vld && s2_ctl.inr;

  always_ff @(posedge clk) begin
    if (adv) begin
      ring_rd_r <= ring_mem[rd_ring_addr];
      sum_rd_r  <= sum_mem[rd_ch];
    end
    if (wr) begin
      ring_mem[s2_addr] <= e;
      sum_mem[s2_idx]   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl;
      if (wr) begin
        lw_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_energy_r <= s2_ctl.inr ? e : '0;
      s3_sum_r    <= s2_ctl.inr ? sum_nxt : '0;
    end
    if (wr) begin
      lw_ch_r  <= s2_idx;
      lw_sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tkema_avg_div.sv
// ----------------------------------------------------------------------------
// tkema_avg_div
// Pipelined divide of sum*16 by the window length, truncated toward zero.
// Sign-magnitude, restoring, eight quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkema_avg_div #(
  parameter int WINDOW_LEN = 15
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire tkema_pkg::item_ctl_t                  in_ctl,
  input  wire logic signed [tkema_pkg::ENERGY_W-1:0] in_energy,
  input  wire logic signed [tkema_pkg::SUM_W-1:0]    in_sum,
  output tkema_pkg::item_ctl_t                       out_ctl,
  output logic signed [tkema_pkg::ENERGY_W-1:0]      out_energy,
  output logic signed [tkema_pkg::AVG_W-1:0]         out_avg
);

  localparam int REM_W = $clog2(WINDOW_LEN);
  localparam int NS    = tkema_pkg::DIV_STAGES;
  localparam logic [REM_W:0] WIN_C = (REM_W + 1)'(WINDOW_LEN);

  tkema_pkg::item_ctl_t                  ctl_r  [NS];
  logic                                  neg_r  [NS];
  logic [REM_W-1:0]                      rem_r  [NS];
  logic [tkema_pkg::NUM_W-1:0]           work_r [NS];
  logic signed [tkema_pkg::ENERGY_W-1:0] en_r   [NS];

  logic [tkema_pkg::SUM_W-1:0]           mag;
  logic [tkema_pkg::NUM_W-1:0]           num;
  logic [tkema_pkg::NUM_W-1:0]           q_s;

  // one digit group: shift dividend bits into the remainder, quotient
  // bits shift into the low end of the same word
  function automatic logic [REM_W+tkema_pkg::NUM_W-1:0] div_step(
    input logic [REM_W-1:0]            rem_i,
    input logic [tkema_pkg::NUM_W-1:0] work_i
  );
    logic [REM_W:0]              t;
    logic [REM_W-1:0]            r;
    logic [tkema_pkg::NUM_W-1:0] w;
    r = rem_i;
    w = work_i;
    for (int i = 0; i < tkema_pkg::DIG_W; i++) begin
      t = {r, w[tkema_pkg::NUM_W-1]};
      w = {w[tkema_pkg::NUM_W-2:0], 1'b0};
      if (t >= WIN_C) begin
        t    = t - WIN_C;
        w[0] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    return {r, w};
  endfunction

  assign mag = in_sum[tkema_pkg::SUM_W-1] ? tkema_pkg::SUM_W'(-in_sum) : in_sum;
  assign num = {mag, {tkema_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        ctl_r[s] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= in_ctl;
      for (int s = 1; s < NS; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {rem_r[0], work_r[0]} <= div_step('0, num);
      neg_r[0]              <= in_sum[tkema_pkg::SUM_W-1];
      en_r[0]               <= in_energy;
      for (int s = 1; s < NS; s++) begin
        {rem_r[s], work_r[s]} <= div_step(rem_r[s-1], work_r[s-1]);
        neg_r[s]              <= neg_r[s-1];
        en_r[s]               <= en_r[s-1];
      end
    end
  end

  assign q_s        = neg_r[NS-1] ? (~work_r[NS-1] + 1'b1) : work_r[NS-1];
  assign out_ctl    = ctl_r[NS-1];
  assign out_energy = en_r[NS-1];
  assign out_avg    = q_s[tkema_pkg::AVG_W-1:0];

endmodule

`default_nettype wire

### rtl/core/tke_moving_average_multichannel_core.sv
// ----------------------------------------------------------------------------
// tke_moving_average_multichannel_core
// Per-channel Teager-Kaiser energy with a moving-average window.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per word, tagged with its channel, and
// returns one word per sample: the channel, the new energy
// E = x[n-1]^2 - x[n-2]*x[n] and the window average sum*16/WINDOW_LEN in Q.4,
// truncated toward zero. Throughput is one word per clock while no result
// waits in the skid register, any channel order, including the same channel
// back to back. On its way to the output a word has the history RAM read on
// the accepting edge, then one stage for the energy ring and sum RAM reads, one
// for the sum update, five for the divider, one for the output register.
// The per-channel state lives in three single-port-write
// RAMs (history CHANNELS deep, ring CHANNELS*WINDOW_LEN deep, sum CHANNELS
// deep); back-to-back writes to the same channel are forwarded, so no
// interlock ever stalls the input. Reset needs no clearing pass: one valid
// flop per channel and a per-channel "ring filled once" flag make unwritten
// state read as zero, so the block takes samples from the first clock after
// reset. A channel tag >= CHANNELS leaves all state alone and returns
// energy 0 and average 0. in_tready is low during reset and otherwise only
// drops while a result waits in the skid register behind a stalled output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tke_moving_average_multichannel_core #(
  parameter int CHANNELS   = 12,
  parameter int WINDOW_LEN = 15
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [tkema_pkg::IN_TDATA_W-1:0]     in_tdata,   // channel[3:0], sample[19:4]
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [tkema_pkg::OUT_TDATA_W-1:0]         out_tdata   // channel_out[3:0],
                                                                // energy[35:4], average[71:36]
);

  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RA_W   = $clog2(CHANNELS * WINDOW_LEN);

  // global advance: the whole pipe moves unless the skid slot is occupied
  logic adv;
  logic in_acc;

  logic [RA_W-1:0]                       rd_ring_addr;
  logic [CIDX_W-1:0]                     rd_ch;
  tkema_pkg::item_ctl_t                  s2_ctl;
  logic signed [tkema_pkg::ENERGY_W-1:0] s2_pa;
  logic signed [tkema_pkg::ENERGY_W-1:0] s2_pb;
  logic [RA_W-1:0]                       s2_addr;
  logic                                  s2_wrap;
  logic                                  s2_seen;

  tkema_pkg::item_ctl_t                  s3_ctl;
  logic signed [tkema_pkg::ENERGY_W-1:0] s3_energy;
  logic signed [tkema_pkg::SUM_W-1:0]    s3_sum;

  tkema_pkg::item_ctl_t                  d_ctl;
  logic signed [tkema_pkg::ENERGY_W-1:0] d_energy;
  logic signed [tkema_pkg::AVG_W-1:0]    d_avg;
  logic [tkema_pkg::OUT_TDATA_W-1:0]     d_word;

  // output register plus one skid slot
  logic                                  out_vld_r, out_vld_nxt;
  logic                                  skid_vld_r, skid_vld_nxt;
  logic [tkema_pkg::OUT_TDATA_W-1:0]     out_dat_r;
  logic [tkema_pkg::OUT_TDATA_W-1:0]     skid_dat_r;
  logic                                  out_load;
  logic                                  skid_load;
  logic                                  from_skid;

  assign adv       = !skid_vld_r;
  // no word is taken while reset is held
  assign in_tready = adv && rst_n;
  assign in_acc    = in_tvalid && in_tready;

  tkema_energy #(
    .CHANNELS   (CHANNELS),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_energy (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_acc       (in_acc),
    .in_ch        (in_tdata[tkema_pkg::CH_W-1:0]),
    .in_x         ($signed(in_tdata[tkema_pkg::CH_W +: tkema_pkg::SAMPLE_W])),
    .rd_ring_addr (rd_ring_addr),
    .rd_ch        (rd_ch),
    .s2_ctl_r     (s2_ctl),
    .s2_pa_r      (s2_pa),
    .s2_pb_r      (s2_pb),
    .s2_addr_r    (s2_addr),
    .s2_wrap_r    (s2_wrap),
    .s2_seen_r    (s2_seen)
  );

  tkema_window #(
    .CHANNELS   (CHANNELS),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .rd_ring_addr (rd_ring_addr),
    .rd_ch        (rd_ch),
    .s2_ctl       (s2_ctl),
    .s2_pa        (s2_pa),
    .s2_pb        (s2_pb),
    .s2_addr      (s2_addr),
    .s2_wrap      (s2_wrap),
    .s2_seen      (s2_seen),
    .s3_ctl_r     (s3_ctl),
    .s3_energy_r  (s3_energy),
    .s3_sum_r     (s3_sum)
  );

  tkema_avg_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_ctl     (s3_ctl),
    .in_energy  (s3_energy),
    .in_sum     (s3_sum),
    .out_ctl    (d_ctl),
    .out_energy (d_energy),
    .out_avg    (d_avg)
  );

  assign d_word = {d_avg, d_energy, d_ctl.ch};

  // Skid control. While the skid slot is full the pipe is frozen and only
  // drains the slot into the output register. Otherwise a finished word goes
  // to the output register if it is free or being taken, else to the slot.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    from_skid    = 1'b0;
    if (skid_vld_r) begin
      if (out_tready) begin
        out_load     = 1'b1;
        from_skid    = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_tready || !out_vld_r) begin
      out_vld_nxt = d_ctl.vld;
      out_load    = d_ctl.vld;
    end else if (d_ctl.vld) begin
      skid_load    = 1'b1;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dat_r <= from_skid ? skid_dat_r : d_word;
    end
    if (skid_load) begin
      skid_dat_r <= d_word;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule

`default_nettype wire

### rtl/core/tkema_checker.sv
// ----------------------------------------------------------------------------
// tkema_checker
// Port-level checks of the energy moving-average core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkema_checker #(
  parameter int CHANNELS = 12
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [tkema_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic [tkema_pkg::CMP_W-1:0] out_ch_ext;
  logic                        out_oor;

  assign out_ch_ext = {{(tkema_pkg::CMP_W-tkema_pkg::CH_W){1'b0}},
                       out_tdata[tkema_pkg::CH_W-1:0]};
  assign out_oor    = out_ch_ext >= tkema_pkg::CMP_W'(CHANNELS);

  // output register comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // input only backs up when a result is held on the output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no result pending");

  // a word for a channel outside the range carries zero energy and average
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_oor |-> out_tdata[tkema_pkg::OUT_TDATA_W-1:tkema_pkg::CH_W] == '0)
    else $error("nonzero result for channel out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

endmodule

bind tke_moving_average_multichannel_core tkema_checker #(
  .CHANNELS (CHANNELS)
) u_tkema_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the multichannel Teager-Kaiser energy average core.
// ----------------------------------------------------------------------------
// Feeds tagged samples through the input stream in random bursts while the
// result side stalls on its own schedule. Every accepted word goes through a
// local model of the per-channel history, energy ring and window sum. Each
// result word is compared with the oldest expected one. A short table of
// directed words covers reset, extreme samples and unused channel tags. A
// long random run follows, with one long output stall and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CHANNELS    = 12;
  localparam int WINDOW_LEN  = 15;
  localparam int DIRECTED_N  = 22;
  localparam int RANDOM_N    = 830;
  localparam int TAIL_CYC    = 16;
  localparam int CYCLE_CAP   = 400000;

  localparam int CH_W        = tkema_pkg::CH_W;
  localparam int SAMPLE_W    = tkema_pkg::SAMPLE_W;
  localparam int ENERGY_W    = tkema_pkg::ENERGY_W;
  localparam int SUM_W       = tkema_pkg::SUM_W;
  localparam int AVG_W       = tkema_pkg::AVG_W;
  localparam int IN_TDATA_W  = tkema_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = tkema_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [ENERGY_W-1:0] energy;
    logic [AVG_W-1:0]    average;
  } tke_result_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
    bit                  fixed_exp;    // expected result typed in below
    logic [ENERGY_W-1:0] energy;
    logic [AVG_W-1:0]    average;
  } tke_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  tke_moving_average_multichannel_core #(
    .CHANNELS   (CHANNELS),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Local model of the per-channel state
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] hist_newer [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_older [CHANNELS];
  longint                     energy_hist [CHANNELS][WINDOW_LEN];
  longint                     win_sum [CHANNELS];
  int                         slot [CHANNELS];

  tke_result_t expected_q [$];
  int          errors      = 0;
  int          n_sent      = 0;
  int          n_unused_ch = 0;
  int          n_checked   = 0;
  int          holds_asked = 0;
  int          cycle_cnt   = 0;

  // Energy E = newer^2 - older*x, ring replace, wrap the sum to 36 bits,
  // then the Q.4 average truncated toward zero.
  function automatic tke_result_t tke_predict(input logic [CH_W-1:0] ch,
                                              input logic signed [SAMPLE_W-1:0] x);
    tke_result_t      r;
    longint           e;
    longint           s;
    longint           q;
    logic [SUM_W-1:0] s_wrap;
    r = '0;
    r.ch = ch;
    if (ch < CHANNELS) begin
      e = longint'(hist_newer[ch]) * longint'(hist_newer[ch])
        - longint'(hist_older[ch]) * longint'(x);
      s_wrap = SUM_W'(win_sum[ch] - energy_hist[ch][slot[ch]] + e);
      s = longint'($signed(s_wrap));
      q = (s * 16) / WINDOW_LEN;
      hist_older[ch] = hist_newer[ch];
      hist_newer[ch] = x;
      win_sum[ch] = s;
      energy_hist[ch][slot[ch]] = e;
      slot[ch] = (slot[ch] == WINDOW_LEN - 1) ? 0 : slot[ch] + 1;
      r.energy = e[ENERGY_W-1:0];
      r.average = q[AVG_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                           input bit fixed_exp, input tke_result_t fixed_r);
    tke_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - SAMPLE_W - CH_W){1'b0}}, smp, ch};
    do @(posedge clk); while (!in_tready);
    r = tke_predict(ch, smp);
    expected_q.push_back(fixed_exp ? fixed_r : r);
    n_sent++;
    if (ch >= CHANNELS) n_unused_ch++;
  endtask

  task automatic idle(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Always waits on a clock edge before returning, so valid never drops and rises in one step
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  tke_row_t directed_rows [DIRECTED_N];

  initial begin : stimulus
    int                         i;
    int                         k;
    int                         burst_left;
    int                         pat_phase [CHANNELS];
    logic [CH_W-1:0]            ch;
    logic [CH_W-1:0]            prev_ch;
    logic signed [SAMPLE_W-1:0] smp;

    // ch, sample, typed, energy, average
    directed_rows = '{
      '{4'd0,  16'h7FFF, 1'b1, 32'd0, 36'd0},  // first word of a channel
      '{4'd0,  16'h8000, 1'b0, 32'd0, 36'd0},
      '{4'd0,  16'h7FFF, 1'b0, 32'd0, 36'd0},
      '{4'd15, 16'h8000, 1'b1, 32'd0, 36'd0},  // unused tags: zeros, no update
      '{4'd12, 16'h7FFF, 1'b1, 32'd0, 36'd0},
      '{4'd13, 16'h5555, 1'b1, 32'd0, 36'd0},
      '{4'd14, 16'hFFFF, 1'b1, 32'd0, 36'd0},
      '{4'd1,  16'h8000, 1'b1, 32'd0, 36'd0},
      '{4'd1,  16'h8000, 1'b0, 32'd0, 36'd0},
      '{4'd1,  16'h7FFF, 1'b0, 32'd0, 36'd0},  // largest energy
      '{4'd1,  16'h7FFF, 1'b0, 32'd0, 36'd0},
      '{4'd2,  16'h8000, 1'b1, 32'd0, 36'd0},
      '{4'd2,  16'h0000, 1'b0, 32'd0, 36'd0},
      '{4'd2,  16'h8000, 1'b0, 32'd0, 36'd0},  // most negative energy
      '{4'd11, 16'h0001, 1'b1, 32'd0, 36'd0},  // top channel
      '{4'd11, 16'hFFFF, 1'b0, 32'd0, 36'd0},
      '{4'd11, 16'hAAAA, 1'b0, 32'd0, 36'd0},
      '{4'd5,  16'h0000, 1'b1, 32'd0, 36'd0},  // all-zero history stays zero
      '{4'd5,  16'h0000, 1'b1, 32'd0, 36'd0},
      '{4'd5,  16'h0000, 1'b1, 32'd0, 36'd0},
      '{4'd0,  16'h0000, 1'b0, 32'd0, 36'd0},
      '{4'd3,  16'h1234, 1'b1, 32'd0, 36'd0}
    };

    for (i = 0; i < CHANNELS; i++) begin
      hist_newer[i] = '0;
      hist_older[i] = '0;
      win_sum[i]    = 0;
      slot[i]       = 0;
      pat_phase[i]  = 0;
      for (k = 0; k < WINDOW_LEN; k++) energy_hist[i][k] = 0;
    end

    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, mostly back to back
    for (i = 0; i < DIRECTED_N; i++) begin
      send_word(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].fixed_exp,
                '{directed_rows[i].ch, directed_rows[i].energy, directed_rows[i].average});
      if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 3));
    end
    drain();

    // random traffic in bursts
    prev_ch    = '0;
    burst_left = $urandom_range(1, 40);
    for (i = 0; i < RANDOM_N; i++) begin
      if (i == RANDOM_N / 2) holds_asked++;          // long output stall, keep offering
      if (i == (3 * RANDOM_N) / 4) drain();

      // pick the channel
      if (i >= 250 && i < 400) begin
        ch = CH_W'($urandom_range(0, 3));            // few channels, windows fill up
      end else begin
        k = $urandom_range(0, 9);
        if (k == 0) ch = CH_W'($urandom_range(CHANNELS, 15));
        else if (k < 4) ch = prev_ch;
        else ch = CH_W'($urandom_range(0, CHANNELS - 1));
      end
      prev_ch = ch;

      // pick the sample
      if (i >= 250 && i < 400 && ch < CHANNELS) begin
        // ++-- pattern keeps every energy near the top, sums near their max
        smp = (pat_phase[ch] < 2) ? 16'sh7FFF : 16'sh8000;
        pat_phase[ch] = (pat_phase[ch] + 1) % 4;
      end else begin
        k = $urandom_range(0, 9);
        case (k)
          3, 4: begin
            case ($urandom_range(0, 4))
              0: smp = 16'sh7FFF;
              1: smp = 16'sh8000;
              2: smp = 16'sh0000;
              3: smp = 16'shFFFF;
              default: smp = 16'sh0001;
            endcase
          end
          5, 6: smp = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
          7: smp = SAMPLE_W'(-int'($urandom_range(16384, 32768)));
          default: smp = SAMPLE_W'($urandom_range(0, 65535));
        endcase
      end

      send_word(ch, smp, 1'b0, '0);

      burst_left--;
      if (burst_left == 0) begin
        idle($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
    end

    drain();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Sent %0d sample words (%0d with unused channel tags), checked %0d results.",
             n_sent, n_unused_ch, n_checked);
    $display("Run included full-scale windows, a long output stall and a full drain.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall pattern with its own modes, plus the long hold
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int holds_done;
    int mode;
    int mode_left;
    int tick;
    hold_left  = 0;
    holds_done = 0;
    mode       = 0;
    mode_left  = 0;
    tick       = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = 120;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 9) != 0);
          default: out_tready <= ((tick % 5) != 4);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    tke_result_t want;
    tke_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ch      = out_tdata[CH_W-1:0];
      got.energy  = out_tdata[CH_W +: ENERGY_W];
      got.average = out_tdata[CH_W + ENERGY_W +: AVG_W];
      if (expected_q.size() == 0) begin
        $error("result word with none expected: channel %0d energy %0d average %0d",
               got.ch, $signed(got.energy), $signed(got.average));
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got.ch !== want.ch) begin
          $error("channel_out: expected %0d, got %0d", want.ch, got.ch);
          errors++;
        end
        if (got.energy !== want.energy) begin
          $error("energy: expected %0d, got %0d", $signed(want.energy), $signed(got.energy));
          errors++;
        end
        if (got.average !== want.average) begin
          $error("average: expected %0d, got %0d",
                 $signed(want.average), $signed(got.average));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_CAP) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_cnt, expected_q.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/core/tkema_pkg.sv
rtl/core/tkema_energy.sv
rtl/core/tkema_window.sv
rtl/core/tkema_avg_div.sv
rtl/core/tke_moving_average_multichannel_core.sv
rtl/core/tkema_checker.sv
verif/testbench.sv
